FILE: design/look_at_view_matrix_macros.svh
`ifndef LOOK_AT_VIEW_MATRIX_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_MACROS_SVH

// same-cycle implication, checked on clk_i, off during reset
`define LAV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("look_at_view_matrix assertion failed");

// next-cycle implication, checked on clk_i, off during reset
`define LAV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("look_at_view_matrix assertion failed");

`endif

FILE: design/lav_pkg.sv
`default_nettype none

package lav_pkg;

  localparam int NumSqrtSt = 31;
  localparam int NumDivSt  = 31;

  typedef struct packed {
    logic             rh;
    logic [2:0][31:0] eye;
    logic [2:0][31:0] up;
    logic [2:0][31:0] f;
  } side_t;

  typedef struct packed {
    logic             zero;
    logic [2:0]       sgn;
    logic [2:0][29:0] a;
    side_t            side;
  } norm_pl_t;

  function automatic logic signed [63:0] mul32(input logic signed [31:0] x,
                                               input logic signed [31:0] y);
    logic signed [63:0] xw;
    logic signed [63:0] yw;
    xw = 64'(x);
    yw = 64'(y);
    return xw * yw;
  endfunction

  function automatic logic signed [65:0] ext66(input logic signed [63:0] x);
    return 66'(x);
  endfunction

  function automatic logic signed [65:0] rnd30(input logic signed [65:0] x);
    logic [65:0] m;
    m = x[65] ? 66'(-x) : 66'(x);
    m = (m + (66'd1 << 29)) >> 30;
    return x[65] ? $signed(-m) : $signed(m);
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [65:0] x);
    logic [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (x < -66'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic [47:0] sat48(input logic signed [65:0] x);
    logic [47:0] r;
    if (x > 66'sd140737488355327) begin
      r = 48'h7fff_ffff_ffff;
    end else if (x < -66'sd140737488355328) begin
      r = 48'h8000_0000_0000;
    end else begin
      r = x[47:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/lav_sqrt.sv
`default_nettype none

module lav_sqrt import lav_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  logic [61:0] n2_i,
  input  norm_pl_t    pl_i,
  output logic        vld_o,
  output logic [30:0] root_o,
  output norm_pl_t    pl_o
);

  logic [62:0] rem_q  [NumSqrtSt];
  logic [30:0] root_q [NumSqrtSt];
  logic        vld_q  [NumSqrtSt];
  norm_pl_t    pl_q   [NumSqrtSt];

  for (genvar k = 0; k < NumSqrtSt; k++) begin : g_st
    localparam int Bit = NumSqrtSt - 1 - k;
    logic [62:0] rem_in;
    logic [30:0] root_in;
    logic        vld_in;
    norm_pl_t    pl_in;
    logic [62:0] trial;
    logic [62:0] rem_d;
    logic [30:0] root_d;

    if (k == 0) begin : g_first
      assign rem_in  = {1'b0, n2_i};
      assign root_in = '0;
      assign vld_in  = vld_i;
      assign pl_in   = pl_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign vld_in  = vld_q[k-1];
      assign pl_in   = pl_q[k-1];
    end

    assign trial = ({32'd0, root_in} << (Bit + 1)) + (63'd1 << (2 * Bit));

    always_comb begin
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = root_in | (31'd1 << Bit);
      end else begin
        rem_d  = rem_in;
        root_d = root_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        pl_q[k]   <= pl_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end
  end

  assign vld_o  = vld_q[NumSqrtSt-1];
  assign root_o = root_q[NumSqrtSt-1];
  assign pl_o   = pl_q[NumSqrtSt-1];

endmodule

`default_nettype wire

FILE: design/lav_div.sv
`default_nettype none

module lav_div import lav_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [30:0]      r_i,
  input  norm_pl_t         pl_i,
  output logic             vld_o,
  output logic [2:0][30:0] q_o,
  output norm_pl_t         pl_o
);

  logic [2:0][61:0] rem_q [NumDivSt];
  logic [2:0][30:0] q_q   [NumDivSt];
  logic [30:0]      r_q   [NumDivSt];
  logic             vld_q [NumDivSt];
  norm_pl_t         pl_q  [NumDivSt];

  for (genvar k = 0; k < NumDivSt; k++) begin : g_st
    localparam int Bit = NumDivSt - 1 - k;
    logic [2:0][61:0] rem_in;
    logic [2:0][30:0] q_in;
    logic [30:0]      r_in;
    logic             vld_in;
    norm_pl_t         pl_in;
    logic [61:0]      dv;
    logic [2:0][61:0] rem_d;
    logic [2:0][30:0] q_d;

    if (k == 0) begin : g_first
      for (genvar l = 0; l < 3; l++) begin : g_num
        assign rem_in[l] = {2'b00, pl_i.a[l], 30'd0} + 62'(r_i >> 1);
      end
      assign q_in   = '0;
      assign r_in   = r_i;
      assign vld_in = vld_i;
      assign pl_in  = pl_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign q_in   = q_q[k-1];
      assign r_in   = r_q[k-1];
      assign vld_in = vld_q[k-1];
      assign pl_in  = pl_q[k-1];
    end

    assign dv = 62'(r_in) << Bit;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (rem_in[l] >= dv) begin
          rem_d[l] = rem_in[l] - dv;
          q_d[l]   = q_in[l] | (31'd1 << Bit);
        end else begin
          rem_d[l] = rem_in[l];
          q_d[l]   = q_in[l];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        q_q[k]   <= q_d;
        r_q[k]   <= r_in;
        pl_q[k]  <= pl_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end
  end

  assign vld_o = vld_q[NumDivSt-1];
  assign q_o   = q_q[NumDivSt-1];
  assign pl_o  = pl_q[NumDivSt-1];

endmodule

`default_nettype wire

FILE: design/lav_norm.sv
`default_nettype none

module lav_norm import lav_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [2:0][63:0] v_i,
  input  side_t            side_i,
  output logic             vld_o,
  output logic [2:0][31:0] o_o,
  output side_t            side_o
);

  logic             vld1_q, vld2_q, vld3_q, vld4_q, vld5_q, vld6_q, vld7_q;
  logic [2:0][63:0] mag1_q, mag2_q, mag3_q;
  logic [63:0]      orw1_q;
  logic [2:0]       sgn1_q, sgn2_q, sgn3_q, sgn4_q, sgn5_q, sgn6_q;
  side_t            side1_q, side2_q, side3_q, side4_q, side5_q, side6_q;
  logic [2:0]       bidx2_q;
  logic [7:0]       byte2_q;
  logic             zero2_q, zero3_q, zero4_q, zero5_q, zero6_q;
  logic [5:0]       pos3_q;
  logic [2:0][29:0] a4_q, a5_q, a6_q;
  logic [2:0][59:0] sq5_q;
  logic [61:0]      n2_6_q;

  logic [2:0][63:0] mag_d;
  logic [2:0]       bidx_d;
  logic [2:0]       bit_d;
  logic [2:0][29:0] a_d;

  logic             sq_vld;
  logic [30:0]      root;
  norm_pl_t         pl6, sq_pl, dv_pl;
  logic             dv_vld;
  logic [2:0][30:0] q;
  logic [2:0][31:0] o_q;
  side_t            side7_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = v_i[i][63] ? 64'(-v_i[i]) : v_i[i];
    end
  end

  always_comb begin
    bidx_d = '0;
    for (int k = 0; k < 8; k++) begin
      if (|orw1_q[8*k +: 8]) begin
        bidx_d = 3'(k);
      end
    end
  end

  always_comb begin
    bit_d = '0;
    for (int k = 0; k < 8; k++) begin
      if (byte2_q[k]) begin
        bit_d = 3'(k);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos3_q >= 6'd29) begin
        a_d[i] = 30'(mag3_q[i] >> (pos3_q - 6'd29));
      end else begin
        a_d[i] = 30'(mag3_q[i] << (6'd29 - pos3_q));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q  <= mag_d;
      orw1_q  <= mag_d[0] | mag_d[1] | mag_d[2];
      sgn1_q  <= {v_i[2][63], v_i[1][63], v_i[0][63]};
      side1_q <= side_i;

      mag2_q  <= mag1_q;
      bidx2_q <= bidx_d;
      byte2_q <= orw1_q[{bidx_d, 3'b000} +: 8];
      zero2_q <= (orw1_q == '0);
      sgn2_q  <= sgn1_q;
      side2_q <= side1_q;

      mag3_q  <= mag2_q;
      pos3_q  <= {bidx2_q, bit_d};
      zero3_q <= zero2_q;
      sgn3_q  <= sgn2_q;
      side3_q <= side2_q;

      a4_q    <= a_d;
      zero4_q <= zero3_q;
      sgn4_q  <= sgn3_q;
      side4_q <= side3_q;

      for (int i = 0; i < 3; i++) begin
        sq5_q[i] <= 60'(a4_q[i]) * 60'(a4_q[i]);
      end
      a5_q    <= a4_q;
      zero5_q <= zero4_q;
      sgn5_q  <= sgn4_q;
      side5_q <= side4_q;

      n2_6_q  <= 62'(sq5_q[0]) + 62'(sq5_q[1]) + 62'(sq5_q[2]);
      a6_q    <= a5_q;
      zero6_q <= zero5_q;
      sgn6_q  <= sgn5_q;
      side6_q <= side5_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
      vld6_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
      vld5_q <= vld4_q;
      vld6_q <= vld5_q;
    end
  end

  assign pl6.zero = zero6_q;
  assign pl6.sgn  = sgn6_q;
  assign pl6.a    = a6_q;
  assign pl6.side = side6_q;

  lav_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .vld_i  (vld6_q),
    .n2_i   (n2_6_q),
    .pl_i   (pl6),
    .vld_o  (sq_vld),
    .root_o (root),
    .pl_o   (sq_pl)
  );

  lav_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .vld_i  (sq_vld),
    .r_i    (root),
    .pl_i   (sq_pl),
    .vld_o  (dv_vld),
    .q_o    (q),
    .pl_o   (dv_pl)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_pl.zero) begin
          o_q[i] <= '0;
        end else if (dv_pl.sgn[i]) begin
          o_q[i] <= -{1'b0, q[i]};
        end else begin
          o_q[i] <= {1'b0, q[i]};
        end
      end
      side7_q <= dv_pl.side;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld7_q <= 1'b0;
    end else if (en_i) begin
      vld7_q <= dv_vld;
    end
  end

  assign vld_o  = vld7_q;
  assign o_o    = o_q;
  assign side_o = side7_q;

endmodule

`default_nettype wire

FILE: design/look_at_view_matrix.sv
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  eye, center, up (xyz, Q16.16)
// out      output     out_valid_o / out_stall_i side, upv, fwd (Q2.30), trans (Q32.16)
// cfg      input      cfg_valid_i / cfg_ready_o right_handed (1 bit)
//
// One transaction per cycle in, one per cycle out, except while a stalled result holds the pipeline.
// The pipeline holds two normalize units, each with 31 square-root and
// 31 divide stages, one result bit per stage.
// Reset clears all valid bits and selects left-handed mode.
// A stalled result freezes the whole pipeline; in_stall_o follows it.
`default_nettype none
`include "look_at_view_matrix_macros.svh"

module look_at_view_matrix import lav_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] eye_x_i,
  input  logic [31:0] eye_y_i,
  input  logic [31:0] eye_z_i,
  input  logic [31:0] center_x_i,
  input  logic [31:0] center_y_i,
  input  logic [31:0] center_z_i,
  input  logic [31:0] up_x_i,
  input  logic [31:0] up_y_i,
  input  logic [31:0] up_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] side_x_o,
  output logic [31:0] side_y_o,
  output logic [31:0] side_z_o,
  output logic [31:0] upv_x_o,
  output logic [31:0] upv_y_o,
  output logic [31:0] upv_z_o,
  output logic [31:0] fwd_x_o,
  output logic [31:0] fwd_y_o,
  output logic [31:0] fwd_z_o,
  output logic [47:0] trans_x_o,
  output logic [47:0] trans_y_o,
  output logic [47:0] trans_z_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  logic             en;
  logic             rh_q;

  logic             vld0_q;
  logic [2:0][32:0] d0_q;
  side_t            side0_q;
  logic [2:0][63:0] v0;

  logic             n1_vld;
  logic [2:0][31:0] n1_f;
  side_t            n1_side;

  logic             vx1_q, vx2_q;
  logic [5:0][63:0] px1_q;
  side_t            sx1_q, sx2_q;
  logic [2:0][63:0] cx2_q;

  logic             n2_vld;
  logic [2:0][31:0] n2_s;
  side_t            n2_side;

  logic             vu1_q, vu2_q, vu3_q, vu4_q, vu5_q, vu6_q;
  logic [5:0][63:0] psf1_q;
  logic [2:0][63:0] pse1_q, pfe1_q, pue4_q;
  logic [2:0][31:0] s1_q, s2_q, s3_q, s4_q, s5_q, s6_q;
  logic [2:0][31:0] f1_q;
  logic [2:0][31:0] col2_2_q, col2_3_q, col2_4_q, col2_5_q, col2_6_q;
  logic [2:0][31:0] eye1_q, eye2_q, eye3_q;
  logic             rh1_q, rh2_q;
  logic [2:0][65:0] c2_q;
  logic [65:0]      ds2_q, df2_q, due5_q;
  logic [2:0][31:0] u3_q, u4_q, u5_q, u6_q;
  logic [47:0]      tx3_q, tx4_q, tx5_q, tx6_q;
  logic [47:0]      tz3_q, tz4_q, tz5_q, tz6_q;
  logic [47:0]      ty6_q;

  assign en          = !(vu6_q && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rh_q <= 1'b0;
    end else if (cfg_valid_i) begin
      rh_q <= cfg_data_i;
    end
  end

  // input stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      d0_q[0]     <= 33'($signed(center_x_i)) - 33'($signed(eye_x_i));
      d0_q[1]     <= 33'($signed(center_y_i)) - 33'($signed(eye_y_i));
      d0_q[2]     <= 33'($signed(center_z_i)) - 33'($signed(eye_z_i));
      side0_q.rh  <= rh_q;
      side0_q.eye <= {eye_z_i, eye_y_i, eye_x_i};
      side0_q.up  <= {up_z_i, up_y_i, up_x_i};
      side0_q.f   <= '0;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v0[i] = {{31{d0_q[i][32]}}, d0_q[i]};
    end
  end

  lav_norm u_norm_fwd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld0_q),
    .v_i    (v0),
    .side_i (side0_q),
    .vld_o  (n1_vld),
    .o_o    (n1_f),
    .side_o (n1_side)
  );

  // up x f, negated for right-handed
  always_ff @(posedge clk_i) begin
    if (en) begin
      px1_q[0] <= mul32(n1_side.up[1], n1_f[2]);
      px1_q[1] <= mul32(n1_side.up[2], n1_f[1]);
      px1_q[2] <= mul32(n1_side.up[2], n1_f[0]);
      px1_q[3] <= mul32(n1_side.up[0], n1_f[2]);
      px1_q[4] <= mul32(n1_side.up[0], n1_f[1]);
      px1_q[5] <= mul32(n1_side.up[1], n1_f[0]);
      sx1_q.rh  <= n1_side.rh;
      sx1_q.eye <= n1_side.eye;
      sx1_q.up  <= n1_side.up;
      sx1_q.f   <= n1_f;

      for (int i = 0; i < 3; i++) begin
        if (sx1_q.rh) begin
          cx2_q[i] <= px1_q[2*i+1] - px1_q[2*i];
        end else begin
          cx2_q[i] <= px1_q[2*i] - px1_q[2*i+1];
        end
      end
      sx2_q <= sx1_q;
    end
  end

  lav_norm u_norm_side (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vx2_q),
    .v_i    (cx2_q),
    .side_i (sx2_q),
    .vld_o  (n2_vld),
    .o_o    (n2_s),
    .side_o (n2_side)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      // f x s, dot products with eye
      psf1_q[0] <= mul32(n2_side.f[1], n2_s[2]);
      psf1_q[1] <= mul32(n2_side.f[2], n2_s[1]);
      psf1_q[2] <= mul32(n2_side.f[2], n2_s[0]);
      psf1_q[3] <= mul32(n2_side.f[0], n2_s[2]);
      psf1_q[4] <= mul32(n2_side.f[0], n2_s[1]);
      psf1_q[5] <= mul32(n2_side.f[1], n2_s[0]);
      for (int i = 0; i < 3; i++) begin
        pse1_q[i] <= mul32(n2_s[i], n2_side.eye[i]);
        pfe1_q[i] <= mul32(n2_side.f[i], n2_side.eye[i]);
      end
      s1_q   <= n2_s;
      f1_q   <= n2_side.f;
      eye1_q <= n2_side.eye;
      rh1_q  <= n2_side.rh;

      for (int i = 0; i < 3; i++) begin
        if (rh1_q) begin
          c2_q[i]     <= ext66(psf1_q[2*i+1]) - ext66(psf1_q[2*i]);
          col2_2_q[i] <= -f1_q[i];
        end else begin
          c2_q[i]     <= ext66(psf1_q[2*i]) - ext66(psf1_q[2*i+1]);
          col2_2_q[i] <= f1_q[i];
        end
      end
      ds2_q  <= ext66(pse1_q[0]) + ext66(pse1_q[1]) + ext66(pse1_q[2]);
      df2_q  <= ext66(pfe1_q[0]) + ext66(pfe1_q[1]) + ext66(pfe1_q[2]);
      s2_q   <= s1_q;
      eye2_q <= eye1_q;
      rh2_q  <= rh1_q;

      for (int i = 0; i < 3; i++) begin
        u3_q[i] <= clamp32(rnd30($signed(c2_q[i])));
      end
      tx3_q <= sat48(-rnd30($signed(ds2_q)));
      if (rh2_q) begin
        tz3_q <= sat48(rnd30($signed(df2_q)));
      end else begin
        tz3_q <= sat48(-rnd30($signed(df2_q)));
      end
      s3_q     <= s2_q;
      col2_3_q <= col2_2_q;
      eye3_q   <= eye2_q;

      for (int i = 0; i < 3; i++) begin
        pue4_q[i] <= mul32(u3_q[i], eye3_q[i]);
      end
      u4_q     <= u3_q;
      s4_q     <= s3_q;
      col2_4_q <= col2_3_q;
      tx4_q    <= tx3_q;
      tz4_q    <= tz3_q;

      due5_q   <= ext66(pue4_q[0]) + ext66(pue4_q[1]) + ext66(pue4_q[2]);
      u5_q     <= u4_q;
      s5_q     <= s4_q;
      col2_5_q <= col2_4_q;
      tx5_q    <= tx4_q;
      tz5_q    <= tz4_q;

      ty6_q    <= sat48(-rnd30($signed(due5_q)));
      u6_q     <= u5_q;
      s6_q     <= s5_q;
      col2_6_q <= col2_5_q;
      tx6_q    <= tx5_q;
      tz6_q    <= tz5_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vx1_q  <= 1'b0;
      vx2_q  <= 1'b0;
      vu1_q  <= 1'b0;
      vu2_q  <= 1'b0;
      vu3_q  <= 1'b0;
      vu4_q  <= 1'b0;
      vu5_q  <= 1'b0;
      vu6_q  <= 1'b0;
    end else if (en) begin
      vld0_q <= in_valid_i;
      vx1_q  <= n1_vld;
      vx2_q  <= vx1_q;
      vu1_q  <= n2_vld;
      vu2_q  <= vu1_q;
      vu3_q  <= vu2_q;
      vu4_q  <= vu3_q;
      vu5_q  <= vu4_q;
      vu6_q  <= vu5_q;
    end
  end

  assign out_valid_o = vu6_q;
  assign side_x_o    = s6_q[0];
  assign side_y_o    = s6_q[1];
  assign side_z_o    = s6_q[2];
  assign upv_x_o     = u6_q[0];
  assign upv_y_o     = u6_q[1];
  assign upv_z_o     = u6_q[2];
  assign fwd_x_o     = col2_6_q[0];
  assign fwd_y_o     = col2_6_q[1];
  assign fwd_z_o     = col2_6_q[2];
  assign trans_x_o   = tx6_q;
  assign trans_y_o   = ty6_q;
  assign trans_z_o   = tz6_q;

  `LAV_ASSERT_IMP(a_stall_hold, out_valid_o && out_stall_i, in_stall_o)
  `LAV_ASSERT_IMP(a_side_zero, out_valid_o && side_x_o == '0 && side_y_o == '0 && side_z_o == '0, upv_x_o == '0 && upv_y_o == '0 && upv_z_o == '0 && trans_x_o == '0)
  `LAV_ASSERT_IMP(a_fwd_zero, out_valid_o && fwd_x_o == '0 && fwd_y_o == '0 && fwd_z_o == '0, side_x_o == '0 && side_y_o == '0 && side_z_o == '0 && trans_z_o == '0)
  `LAV_ASSERT_NXT(a_stall_keep, out_valid_o && out_stall_i, out_valid_o)

endmodule

`default_nettype wire

FILE: tb/sv/look_at_view_matrix_checker.sv
`timescale 1ns / 1ps

module look_at_view_matrix_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] eye_x_i,
  input  logic [31:0] eye_y_i,
  input  logic [31:0] eye_z_i,
  input  logic [31:0] center_x_i,
  input  logic [31:0] center_y_i,
  input  logic [31:0] center_z_i,
  input  logic [31:0] up_x_i,
  input  logic [31:0] up_y_i,
  input  logic [31:0] up_z_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] side_x_i,
  input  logic [31:0] side_y_i,
  input  logic [31:0] side_z_i,
  input  logic [31:0] upv_x_i,
  input  logic [31:0] upv_y_i,
  input  logic [31:0] upv_z_i,
  input  logic [31:0] fwd_x_i,
  input  logic [31:0] fwd_y_i,
  input  logic [31:0] fwd_z_i,
  input  logic [47:0] trans_x_i,
  input  logic [47:0] trans_y_i,
  input  logic [47:0] trans_z_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_data_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          matrices_o
);

  typedef longint vec3_t[3];
  typedef struct {
    logic [47:0] v[12];
  } view_mat_t;

  view_mat_t   matrix_q[$];
  logic        right_handed;
  string       field_name[12] = '{"side_x", "side_y", "side_z", "upv_x", "upv_y", "upv_z",
                                  "fwd_x", "fwd_y", "fwd_z", "trans_x", "trans_y", "trans_z"};

  function automatic longint unsigned mag(longint x);
    return x < 0 ? longint'(0) - x : x;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint rnd_q30(longint x);
    longint unsigned m;
    m = (mag(x) + (64'd1 << 29)) >> 30;
    return x < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic void unit_vec(input vec3_t v, output vec3_t o);
    longint unsigned a[3];
    longint unsigned mx;
    longint unsigned n2;
    longint unsigned r;
    mx = 0;
    n2 = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = mag(v[i]);
      if (a[i] > mx) mx = a[i];
    end
    if (mx == 0) begin
      o = '{0, 0, 0};
      return;
    end
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
    end
    for (int i = 0; i < 3; i++) n2 += a[i] * a[i];
    r = int_sqrt(n2);
    for (int i = 0; i < 3; i++) begin
      o[i] = longint'(((a[i] << 30) + (r >> 1)) / r);
      if (v[i] < 0) o[i] = -o[i];
    end
  endfunction

  function automatic void cross_prod(input vec3_t a, input vec3_t b, output vec3_t c);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic logic [47:0] translation(vec3_t a, vec3_t e, bit neg);
    longint d;
    d = rnd_q30(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]);
    if (neg) d = -d;
    if (d > 64'sh7fff_ffff_ffff) d = 64'sh7fff_ffff_ffff;
    if (d < -64'sh8000_0000_0000) d = -64'sh8000_0000_0000;
    return d[47:0];
  endfunction

  function automatic view_mat_t view_matrix(logic rh, vec3_t eye, vec3_t ctr, vec3_t up);
    view_mat_t m;
    vec3_t     d;
    vec3_t     f;
    vec3_t     c;
    vec3_t     s;
    vec3_t     u;
    longint    t;
    for (int i = 0; i < 3; i++) d[i] = ctr[i] - eye[i];
    unit_vec(d, f);
    if (rh) cross_prod(f, up, c);
    else cross_prod(up, f, c);
    unit_vec(c, s);
    if (rh) cross_prod(s, f, c);
    else cross_prod(f, s, c);
    for (int i = 0; i < 3; i++) begin
      t = rnd_q30(c[i]);
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      u[i] = t;
      m.v[i] = 48'(s[i][31:0]);
      m.v[3 + i] = 48'(u[i][31:0]);
      t = rh ? -f[i] : f[i];
      m.v[6 + i] = 48'(t[31:0]);
    end
    m.v[9] = translation(s, eye, 1'b1);
    m.v[10] = translation(u, eye, 1'b1);
    m.v[11] = translation(f, eye, !rh);
    return m;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    view_mat_t exp_m;
    view_mat_t act_m;
    vec3_t     eye;
    vec3_t     ctr;
    vec3_t     up;
    bit        bad;
    if (!rst_ni) begin
      right_handed = 1'b0;
      matrix_q.delete();
      fail_cnt_o = 0;
      matrices_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        eye = '{longint'($signed(eye_x_i)), longint'($signed(eye_y_i)),
                longint'($signed(eye_z_i))};
        ctr = '{longint'($signed(center_x_i)), longint'($signed(center_y_i)),
                longint'($signed(center_z_i))};
        up = '{longint'($signed(up_x_i)), longint'($signed(up_y_i)),
               longint'($signed(up_z_i))};
        matrix_q.push_back(view_matrix(right_handed, eye, ctr, up));
      end
      if (out_valid_i && !out_stall_i) begin
        act_m.v = '{48'(side_x_i), 48'(side_y_i), 48'(side_z_i), 48'(upv_x_i),
                    48'(upv_y_i), 48'(upv_z_i), 48'(fwd_x_i), 48'(fwd_y_i),
                    48'(fwd_z_i), trans_x_i, trans_y_i, trans_z_i};
        matrices_o++;
        if (matrix_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10) $display("result with no matrix pending");
        end else begin
          exp_m = matrix_q.pop_front();
          bad = 1'b0;
          for (int i = 0; i < 12; i++) begin
            if (act_m.v[i] !== exp_m.v[i]) begin
              bad = 1'b1;
              if (fail_cnt_o < 10)
                $display("mismatch %s: expected %h actual %h", field_name[i],
                         exp_m.v[i], act_m.v[i]);
            end
          end
          if (bad) fail_cnt_o++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) right_handed = cfg_data_i;
    end
  end

  assign pending_o = matrix_q.size();

endmodule

FILE: tb/sv/look_at_view_matrix_tb.sv
`timescale 1ns / 1ps

module look_at_view_matrix_tb;

  localparam int Latency = 147;
  localparam int CycleLimit = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] eye_x_i = '0, eye_y_i = '0, eye_z_i = '0;
  logic [31:0] center_x_i = '0, center_y_i = '0, center_z_i = '0;
  logic [31:0] up_x_i = '0, up_y_i = '0, up_z_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] side_x_o, side_y_o, side_z_o;
  logic [31:0] upv_x_o, upv_y_o, upv_z_o;
  logic [31:0] fwd_x_o, fwd_y_o, fwd_z_o;
  logic [47:0] trans_x_o, trans_y_o, trans_z_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;

  logic        in_taken = 1'b0;
  logic        cfg_taken = 1'b0;
  int          fail_cnt;
  int          pending;
  int          matrices;
  int          cycles = 0;
  int          sent = 0;
  int          hand_writes = 0;
  bit          stall_quiet = 1'b0;

  always #4 clk_i = ~clk_i;

  look_at_view_matrix i_dut (.*);

  look_at_view_matrix_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .eye_x_i, .eye_y_i, .eye_z_i, .center_x_i, .center_y_i, .center_z_i,
    .up_x_i, .up_y_i, .up_z_i, .out_valid_i(out_valid_o), .out_stall_i,
    .side_x_i(side_x_o), .side_y_i(side_y_o), .side_z_i(side_z_o),
    .upv_x_i(upv_x_o), .upv_y_i(upv_y_o), .upv_z_i(upv_z_o),
    .fwd_x_i(fwd_x_o), .fwd_y_i(fwd_y_o), .fwd_z_i(fwd_z_o),
    .trans_x_i(trans_x_o), .trans_y_i(trans_y_o), .trans_z_i(trans_z_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .matrices_o(matrices)
  );

  always @(posedge clk_i) begin
    in_taken <= in_valid_i && !in_stall_o;
    cfg_taken <= cfg_valid_i && cfg_ready_o;
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 30);
  endfunction

  // drive the result-side stall
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (stall_quiet) begin
        out_stall_i <= 1'b0;
      end else begin
        n = gap_len();
        out_stall_i <= (n != 0);
        repeat (n > 0 ? n - 1 : 0) @(negedge clk_i);
        if (n != 0) begin
          @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  task automatic send_view(logic [31:0] ex, ey, ez, cx, cy, cz, ux, uy, uz);
    eye_x_i <= ex; eye_y_i <= ey; eye_z_i <= ez;
    center_x_i <= cx; center_y_i <= cy; center_z_i <= cz;
    up_x_i <= ux; up_y_i <= uy; up_z_i <= uz;
    in_valid_i <= 1'b1;
    do @(negedge clk_i); while (!in_taken);
    sent++;
  endtask

  task automatic idle_gap();
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);
  endtask

  task automatic set_handed(logic rh);
    cfg_data_i <= rh;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
    hand_writes++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
      2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      default: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff - $urandom_range(0, 3)
                                                     : 32'h8000_0000 + $urandom_range(0, 3);
    endcase
  endfunction

  task automatic random_views(int n);
    logic [31:0] e[3];
    logic [31:0] c[3];
    logic [31:0] u[3];
    int          k;
    for (int j = 0; j < n; j++) begin
      for (int i = 0; i < 3; i++) begin
        e[i] = rand_coord();
        c[i] = rand_coord();
        u[i] = rand_coord();
      end
      case ($urandom_range(0, 9))
        0: c = e;
        1: u = '{0, 0, 0};
        2: begin
          // up along the viewing direction, scaled
          k = $urandom_range(1, 3);
          for (int i = 0; i < 3; i++) begin
            e[i] = 32'($signed($urandom_range(0, 2000 << 16)) - (1000 << 16));
            c[i] = 32'($signed($urandom_range(0, 2000 << 16)) - (1000 << 16));
            u[i] = 32'(($signed(c[i]) - $signed(e[i])) >>> k);
          end
        end
        default: ;
      endcase
      send_view(e[0], e[1], e[2], c[0], c[1], c[2], u[0], u[1], u[2]);
      if (!stall_quiet) idle_gap();
    end
  endtask

  task automatic directed_views();
    localparam logic [31:0] One = 32'h0001_0000;
    localparam logic [31:0] Mx = 32'h7fff_ffff;
    localparam logic [31:0] Mn = 32'h8000_0000;
    send_view(0, 0, 0, 0, 0, One, 0, One, 0);
    send_view(0, 0, 5 * One, 0, 0, 0, 0, One, 0);
    send_view(One, 2 * One, 3 * One, One, 2 * One, 3 * One, 0, One, 0);
    send_view(0, 0, 0, One, One, One, 0, 0, 0);
    send_view(0, 0, 0, 0, One, 0, 0, One, 0);
    send_view(0, 0, 0, 0, One, 0, 0, -3 * One, 0);
    send_view(Mx, Mx, Mx, Mn, Mn, Mn, 0, One, 0);
    send_view(Mn, Mn, Mn, Mx, Mx, Mx, Mn, Mx, Mn);
    send_view(Mx, Mn, Mx, Mn, Mx, Mn, Mx, Mx, Mx);
    send_view(Mn, 0, Mx, Mx, 0, Mn, Mn, Mn, Mn);
    send_view(-One, -One, -One, One, One, One, One, 0, -One);
    send_view(Mx, Mx, Mx, Mx, Mx, Mx - 1, 32'hffff_ffff, 1, 0);
    send_view(0, 0, 0, 1, 0, 0, 0, 0, 1);
    send_view(Mn, Mn, Mn, 0, 0, 0, Mx, 0, 0);
    send_view(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, 1, 1, 1);
    send_view(100 * One, -50 * One, 7 * One, -3 * One, 20 * One, 0, 0, 0, One);
    in_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    directed_views();
    drain();
    set_handed(1'b1);
    directed_views();
    random_views(400);
    drain();
    set_handed(1'b0);
    random_views(300);
    // hold off until the pipeline is empty
    drain();
    stall_quiet = 1'b1;
    random_views(200);
    stall_quiet = 1'b0;
    drain();
    set_handed(1'b1);
    random_views(400);
    drain();
    set_handed(1'b0);
    random_views(380);
    drain();
    $display("%0d view setups sent, %0d matrices checked, %0d handedness writes",
             sent, matrices, hand_writes);
    $display("covered both handedness modes, degenerate eye/center and up cases, extremes");
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: look_at_view_matrix.f
+incdir+design
design/lav_pkg.sv
design/lav_sqrt.sv
design/lav_div.sv
design/lav_norm.sv
design/look_at_view_matrix.sv
tb/sv/look_at_view_matrix_checker.sv
tb/sv/look_at_view_matrix_tb.sv
